// ===== rtl/dtsl_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dtsl_pkg
// Shared types, constants and helpers for the nucleotide trie lookup block.
// ============================================================================
package dtsl_pkg;

   // Default sizing
   localparam int unsigned NODES_DEFAULT     = 4096;
   localparam int unsigned SHIFT_MAX_DEFAULT = 1023;

   // Field widths fixed by the request and response formats
   localparam int unsigned NODE_IDX_W = 12;
   localparam int unsigned SLOT_W     = 3;
   localparam int unsigned SYMBOL_W   = 8;
   localparam int unsigned READ_W     = 32;
   localparam int unsigned SHIFT_W    = 10;
   localparam int unsigned EDGE_W     = NODE_IDX_W + 1;
   localparam int unsigned SLOTS      = 5;

   // Request opcodes
   localparam logic OP_EDGE   = 1'b0;
   localparam logic OP_SYMBOL = 1'b1;

   // Edge slots
   localparam logic [SLOT_W-1:0] SLOT_A     = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_C     = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_G     = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_T     = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_OTHER = 3'd4;

   // Character codes
   localparam logic [SYMBOL_W-1:0] CHAR_A = 8'h41;
   localparam logic [SYMBOL_W-1:0] CHAR_C = 8'h43;
   localparam logic [SYMBOL_W-1:0] CHAR_G = 8'h47;
   localparam logic [SYMBOL_W-1:0] CHAR_T = 8'h54;

   localparam logic [NODE_IDX_W-1:0] ROOT_NODE = 12'd1;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } dtsl_state_type;

   // Map a raw character to its edge slot
   function automatic logic [SLOT_W-1:0] symbol_slot(input logic [SYMBOL_W-1:0] sym);
      logic [SLOT_W-1:0] s;
      case (sym)
         CHAR_A:  s = SLOT_A;
         CHAR_C:  s = SLOT_C;
         CHAR_G:  s = SLOT_G;
         CHAR_T:  s = SLOT_T;
         default: s = SLOT_OTHER;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/dtsl_channels.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dtsl_channels
// Valid/ready channel interfaces for trie requests and match responses.
// ============================================================================
interface dtsl_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 op;
   logic [dtsl_pkg::NODE_IDX_W-1:0]      cell_req;
   logic [dtsl_pkg::SLOT_W-1:0]          slot;
   logic                                 ends_flag;
   logic [dtsl_pkg::NODE_IDX_W-1:0]      child;
   logic [dtsl_pkg::SYMBOL_W-1:0]        symbol;
   logic                                 last;
   logic [dtsl_pkg::READ_W-1:0]          read_id;
   logic [dtsl_pkg::SHIFT_W-1:0]         shift;

   modport source (
      output valid, op, cell_req, slot, ends_flag, child, symbol, last, read_id, shift,
      input  ready
   );
   modport sink (
      input  valid, op, cell_req, slot, ends_flag, child, symbol, last, read_id, shift,
      output ready
   );
endinterface

interface dtsl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [dtsl_pkg::READ_W-1:0]          match_read;
   logic [dtsl_pkg::SHIFT_W-1:0]         match_shift;
   logic [dtsl_pkg::NODE_IDX_W-1:0]      match_node;

   modport source (
      output valid, match_read, match_shift, match_node,
      input  ready
   );
   modport sink (
      input  valid, match_read, match_shift, match_node,
      output ready
   );
endinterface

// ===== rtl/dtsl_edge_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dtsl_edge_ram
// Single-port-write, single-port-read edge memory with registered read data.
// ============================================================================
module dtsl_edge_ram #(
   parameter int unsigned DEPTH  = dtsl_pkg::NODES_DEFAULT * dtsl_pkg::SLOTS,
   parameter int unsigned ADDR_W = $clog2(DEPTH),
   parameter int unsigned DATA_W = dtsl_pkg::EDGE_W
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write one edge word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one edge word, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dna_trie_string_lookup_top.sv =====
`timescale 1ns / 1ps
// A five-way nucleotide trie of NODES nodes (five 13-bit edge words each) is
// held in one synchronous edge memory. A symbol request of a live walk does
// one memory read addressed by the current node, then the step to the child
// in the lookup state; no new request is taken until the walk is back in
// idle. A symbol request after the walk has died needs no memory read. A
// match result sits in an output register, so requests keep flowing while it
// waits; only a second match waiting on a full output register stalls. The
// edge memory has no reset or clearing pass: every entry must be written
// before a walk reads it.
// ============================================================================
// dna_trie_string_lookup_top
// Loads trie edges and walks strings one symbol at a time, reporting matches.
// ============================================================================
module dna_trie_string_lookup_top #(
   parameter int unsigned NODES     = dtsl_pkg::NODES_DEFAULT,
   parameter int unsigned SHIFT_MAX = dtsl_pkg::SHIFT_MAX_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   dtsl_req_if.sink         req_ch,
   dtsl_rsp_if.source       rsp_ch
);

   localparam int unsigned NodeW     = $clog2(NODES);
   localparam int unsigned EdgeDepth = NODES * dtsl_pkg::SLOTS;
   localparam int unsigned AddrW     = $clog2(EdgeDepth);
   localparam int unsigned CmpW      = 17;
   localparam int unsigned IdxW      = dtsl_pkg::NODE_IDX_W;

   dtsl_pkg::dtsl_state_type state_ff, state_in;

   logic [IdxW-1:0]                  cursor_ff, cursor_in;
   logic                             walk_dead_ff, walk_dead_in;
   logic                             last_ff;
   logic [dtsl_pkg::READ_W-1:0]      read_ff;
   logic [dtsl_pkg::SHIFT_W-1:0]     shift_ff, shift_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [dtsl_pkg::READ_W-1:0]      rsp_read_ff;
   logic [dtsl_pkg::SHIFT_W-1:0]     rsp_shift_ff;
   logic [IdxW-1:0]                  rsp_node_ff;
   logic                             rsp_load;

   logic                             req_fire;
   logic                             out_free;
   logic [NodeW+IdxW-1:0]            wnode_ext, rnode_ext;
   logic [NodeW-1:0]                 wnode, rnode;
   logic [dtsl_pkg::SLOT_W-1:0]      rslot;
   logic [AddrW-1:0]                 wr_addr, rd_addr;
   logic                             wr_en, rd_en;
   logic [dtsl_pkg::EDGE_W-1:0]      wr_data, rd_data;
   logic [IdxW-1:0]                  rd_child;
   logic [CmpW-1:0]                  shift_ext, shift_lim;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == dtsl_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Mask node indices to the trie size
   assign wnode_ext = (NodeW + IdxW)'(req_ch.cell_req);
   assign rnode_ext = (NodeW + IdxW)'(cursor_ff);
   assign wnode     = wnode_ext[NodeW-1:0];
   assign rnode     = rnode_ext[NodeW-1:0];
   assign rslot     = dtsl_pkg::symbol_slot(req_ch.symbol);

   // Address = node * 5 + slot
   assign wr_addr = (AddrW'(wnode) << 2) + AddrW'(wnode) + AddrW'(req_ch.slot);
   assign rd_addr = (AddrW'(rnode) << 2) + AddrW'(rnode) + AddrW'(rslot);
   assign wr_data = {req_ch.ends_flag, req_ch.child};
   assign wr_en   = req_fire && (req_ch.op == dtsl_pkg::OP_EDGE)
                    && (req_ch.slot <= dtsl_pkg::SLOT_OTHER);
   assign rd_en   = req_fire && (req_ch.op == dtsl_pkg::OP_SYMBOL) && !walk_dead_ff;
   assign rd_child = rd_data[IdxW-1:0];

   // Limit the reported offset
   assign shift_ext = CmpW'(req_ch.shift);
   assign shift_lim = CmpW'(SHIFT_MAX);
   always_comb begin
      logic [CmpW-1:0] lim;
      lim = (shift_ext > shift_lim) ? shift_lim : shift_ext;
      shift_in = lim[dtsl_pkg::SHIFT_W-1:0];
   end

   dtsl_edge_ram #(
      .DEPTH  (EdgeDepth),
      .ADDR_W (AddrW),
      .DATA_W (dtsl_pkg::EDGE_W)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state of the walk
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      walk_dead_in = walk_dead_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         dtsl_pkg::ST_IDLE: begin
            if (req_fire && (req_ch.op == dtsl_pkg::OP_SYMBOL)) begin
               if (walk_dead_ff) begin
                  if (req_ch.last) begin
                     cursor_in    = dtsl_pkg::ROOT_NODE;
                     walk_dead_in = 1'b0;
                  end
               end else begin
                  state_in = dtsl_pkg::ST_LOOKUP;
               end
            end
         end
         dtsl_pkg::ST_LOOKUP: begin
            if (rd_child == '0) begin
               state_in     = dtsl_pkg::ST_IDLE;
               walk_dead_in = !last_ff;
               if (last_ff) begin
                  cursor_in = dtsl_pkg::ROOT_NODE;
               end
            end else if (last_ff) begin
               // hold until the output register can take the match
               if (out_free) begin
                  rsp_load  = 1'b1;
                  state_in  = dtsl_pkg::ST_IDLE;
                  cursor_in = dtsl_pkg::ROOT_NODE;
               end
            end else begin
               state_in  = dtsl_pkg::ST_IDLE;
               cursor_in = rd_child;
            end
         end
         default: begin
            state_in = dtsl_pkg::ST_IDLE;
         end
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtsl_pkg::ST_IDLE;
         cursor_ff    <= dtsl_pkg::ROOT_NODE;
         walk_dead_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         walk_dead_ff <= walk_dead_in;
      end
   end

   // Capture the request fields of a live symbol
   always_ff @(posedge clock) begin
      if (rd_en) begin
         last_ff  <= req_ch.last;
         read_ff  <= req_ch.read_id;
         shift_ff <= shift_in;
      end
   end

   // Output register
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_read_ff  <= read_ff;
         rsp_shift_ff <= shift_ff;
         rsp_node_ff  <= rd_child;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_read  = rsp_read_ff;
   assign rsp_ch.match_shift = rsp_shift_ff;
   assign rsp_ch.match_node  = rsp_node_ff;

   // A live symbol always moves on to the lookup step
   a_live_to_lookup: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == dtsl_pkg::ST_LOOKUP))
      else $error("live symbol did not start a lookup");

   // A lookup never runs on a dead walk
   a_lookup_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtsl_pkg::ST_LOOKUP) |-> !walk_dead_ff)
      else $error("lookup running on a dead walk");

   // The cursor never points at the null node
   a_cursor_nonzero: assert property (@(posedge clock) disable iff (reset)
      cursor_ff != '0)
      else $error("cursor reached the null node");

   // A finished last-symbol lookup rearms the walk at the root
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == dtsl_pkg::ST_LOOKUP) && last_ff
       && (state_in == dtsl_pkg::ST_IDLE))
      |=> ((cursor_ff == dtsl_pkg::ROOT_NODE) && !walk_dead_ff))
      else $error("walk not rearmed after last symbol");

   // A loaded match always carries a present child
   a_match_node: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && (rsp_node_ff != '0)))
      else $error("match loaded with a null node");

endmodule
